// ===== design/parity_filter_seven_bit_packer_top_defines.svh =====
// ----------------------------------------------------------------------------
// parity filter seven bit packer assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef PARITY_FILTER_SEVEN_BIT_PACKER_TOP_DEFINES_SVH
`define PARITY_FILTER_SEVEN_BIT_PACKER_TOP_DEFINES_SVH

// implication checked on the following cycle
`define PFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfsp assertion failed");

// implication checked on the same cycle
`define PFSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfsp assertion failed");

`endif

// ===== design/pfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsp_pkg
// constants and types for the parity filter seven bit packer
// ----------------------------------------------------------------------------
`default_nettype none

package pfsp_pkg;

    localparam int unsigned DATA_BITS   = 7;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned GROUP_BYTES = 8;
    localparam int unsigned OUT_BYTES   = 7;
    localparam int unsigned ACC_BITS    = DATA_BITS * (GROUP_BYTES - 1);
    localparam int unsigned WORD_BITS   = DATA_BITS * GROUP_BYTES;
    localparam int unsigned CNT_BITS    = 3;

    typedef logic [BYTE_BITS-1:0] t_byte;
    typedef logic [DATA_BITS-1:0] t_data7;
    typedef logic [ACC_BITS-1:0]  t_acc;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    localparam t_cnt LAST_SLOT = t_cnt'(GROUP_BYTES - 1);
    localparam t_cnt OUT_COUNT = t_cnt'(OUT_BYTES);
    localparam t_cnt ONE_LEFT  = t_cnt'(1);

endpackage

`default_nettype wire

// ===== design/pfsp_if.sv =====
// ----------------------------------------------------------------------------
// pfsp stream interfaces
// valid/ready channels for raw input bytes and packed output bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface pfsp_in_if;
    logic           valid;
    logic           ready;
    pfsp_pkg::t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pfsp_out_if;
    logic           valid;
    logic           ready;
    pfsp_pkg::t_byte packed_byte;
    logic           last_of_group;

    modport source (output valid, output packed_byte, output last_of_group, input ready);
    modport sink   (input valid, input packed_byte, input last_of_group, output ready);
endinterface

`default_nettype wire

// ===== design/parity_filter_seven_bit_packer_top.sv =====
// ----------------------------------------------------------------------------
// parity_filter_seven_bit_packer_top
// drops bytes with bad even parity, packs the seven data bits of eight good
// bytes into seven output bytes, msb first, last one flagged
// ----------------------------------------------------------------------------
//  channel   dir  payload                          transaction
//  i_in      in   data_byte[7:0]                   valid & ready
//  o_out     out  packed_byte[7:0], last_of_group  valid & ready
//
//  one input transaction per cycle while not stalled; a completed group leaves as
//  seven bytes from a 56-bit output shift register while the receiver is ready
//  input stalls only while seven good bytes are held and the previous group
//  still has more than one byte to leave, or its last byte is held off
//  synchronous active-low reset clears counts; data registers hold no reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "parity_filter_seven_bit_packer_top_defines.svh"

module parity_filter_seven_bit_packer_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pfsp_in_if.sink     i_in,
    pfsp_out_if.source  o_out
);

    pfsp_pkg::t_cnt   r_count;
    pfsp_pkg::t_cnt   n_count;
    pfsp_pkg::t_acc   r_acc;
    pfsp_pkg::t_acc   n_acc;
    pfsp_pkg::t_word  r_word;
    pfsp_pkg::t_word  n_word;
    pfsp_pkg::t_cnt   r_left;
    pfsp_pkg::t_cnt   n_left;

    pfsp_pkg::t_data7 w_data7;
    logic             w_par_ok;
    logic             w_in_take;
    logic             w_out_take;
    logic             w_good;
    logic             w_complete;
    logic             w_block;

    assign w_data7    = i_in.data_byte[pfsp_pkg::BYTE_BITS-1:1];
    assign w_par_ok   = ~(^i_in.data_byte);
    assign w_out_take = o_out.valid && o_out.ready;
    assign w_block    = (r_count == pfsp_pkg::LAST_SLOT) &&
                        ((r_left > pfsp_pkg::ONE_LEFT) ||
                         ((r_left == pfsp_pkg::ONE_LEFT) && !o_out.ready));
    assign i_in.ready = !w_block;
    assign w_in_take  = i_in.valid && i_in.ready;
    assign w_good     = w_in_take && w_par_ok;
    assign w_complete = w_good && (r_count == pfsp_pkg::LAST_SLOT);

    assign o_out.valid         = (r_left != '0);
    assign o_out.packed_byte   = r_word[pfsp_pkg::WORD_BITS-1 -: pfsp_pkg::BYTE_BITS];
    assign o_out.last_of_group = (r_left == pfsp_pkg::ONE_LEFT);

    always_comb begin
        n_count = r_count;
        n_acc   = r_acc;
        n_word  = r_word;
        n_left  = r_left;
        if (w_out_take) begin
            n_word = r_word << pfsp_pkg::BYTE_BITS;
            n_left = r_left - pfsp_pkg::ONE_LEFT;
        end
        if (w_complete) begin
            n_word  = {r_acc, w_data7};
            n_left  = pfsp_pkg::OUT_COUNT;
            n_count = '0;
        end else if (w_good) begin
            n_acc   = {r_acc[pfsp_pkg::ACC_BITS-pfsp_pkg::DATA_BITS-1:0], w_data7};
            n_count = r_count + pfsp_pkg::ONE_LEFT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_word <= n_word;
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    `PFSP_ASSERT_NEXT(a_bad_parity_holds, i_clk, i_rst_n, w_in_take && !w_par_ok, $stable(r_count))
    `PFSP_ASSERT_NEXT(a_group_loads, i_clk, i_rst_n, w_complete, r_left == pfsp_pkg::OUT_COUNT)
    `PFSP_ASSERT_NEXT(a_last_empties, i_clk, i_rst_n, w_out_take && o_out.last_of_group,
        r_left == '0 || r_left == pfsp_pkg::OUT_COUNT)
    `PFSP_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, w_complete,
        r_left == '0 || (r_left == pfsp_pkg::ONE_LEFT && w_out_take))

endmodule

`default_nettype wire
